// File: hdl/ssw_pkg.sv
// package for the sliding-window subarray sum block
// holds field widths, status codes and default sizes; no dependencies

package ssw_pkg;

    // default array length limit
    localparam int MAX_LEN_DEF = 1024;

    // fixed field widths
    localparam int ELEM_W   = 16;
    localparam int TARGET_W = 32;
    localparam int TOTAL_W  = 33;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_MATCH    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

endpackage

// File: hdl/subarray_sum_sliding_window_top.sv
// top level of the sliding-window subarray sum block
// depends on ssw_pkg and ssw_ram
//
//  channel  direction  handshake                 payload
//  in       sink       i_in_valid / o_in_stall   i_element_value, i_last_element
//  out      source     o_out_valid / i_out_stall o_status, o_window_first, o_window_last
//  cfg      sink       i_cfg_we                  i_cfg_wdata (target sum)
//
// an item is taken in ST_IDLE, then ST_SHRINK drops elements from the window before it finishes;
// the drop loop reads the element store once per cycle through its read port
// reset clears the window, counters and target; the element store needs no clearing
// a result waiting under i_out_stall does not block the next item from being taken,
// but an item that must report holds its finishing cycle until the output slot frees

module subarray_sum_sliding_window_top #(
    parameter int MAX_LEN = ssw_pkg::MAX_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ssw_pkg::TARGET_W-1:0]  i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ssw_pkg::ELEM_W-1:0]    i_element_value,
    input  logic                          i_last_element,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ssw_pkg::STATUS_W-1:0]  o_status,
    output logic [ssw_pkg::INDEX_W-1:0]   o_window_first,
    output logic [ssw_pkg::INDEX_W-1:0]   o_window_last
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 2);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SHRINK
    } t_state;

    t_state                       r_state, n_state;
    logic [ssw_pkg::TARGET_W-1:0] r_target, n_target;
    logic [ssw_pkg::TOTAL_W-1:0]  r_total, n_total;
    logic [AW-1:0]                r_head, n_head;
    logic [AW-1:0]                r_k, n_k;
    logic [CW-1:0]                r_count, n_count;
    logic                         r_match, n_match;
    logic                         r_active, n_active;
    logic                         r_last, n_last;
    logic                         r_out_valid, n_out_valid;
    logic [ssw_pkg::STATUS_W-1:0] r_status, n_status;
    logic [ssw_pkg::INDEX_W-1:0]  r_first, n_first;
    logic [ssw_pkg::INDEX_W-1:0]  r_wlast, n_wlast;

    logic                         mem_we;
    logic [ssw_pkg::ELEM_W-1:0]   rd_data;
    logic                         out_free;
    logic                         hit;
    logic                         emit;
    logic                         pop;
    logic [ssw_pkg::TOTAL_W-1:0]  target_ext;

    // element store, read address follows the next window head
    ssw_ram #(
        .WIDTH (ssw_pkg::ELEM_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_element_value),
        .i_raddr (n_head),
        .o_rdata (rd_data)
    );

    assign target_ext = {1'b0, r_target};
    assign out_free   = !r_out_valid || !i_out_stall;
    assign pop        = r_active && (r_total > target_ext) && (r_head < r_k);
    assign hit        = r_active && (r_total == target_ext);
    assign emit       = hit || (r_last && !r_match);

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_target    = r_target;
        n_total     = r_total;
        n_head      = r_head;
        n_k         = r_k;
        n_count     = r_count;
        n_match     = r_match;
        n_active    = r_active;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_first     = r_first;
        n_wlast     = r_wlast;
        mem_we      = 1'b0;

        // target sum register
        if (i_cfg_we) begin
            n_target = i_cfg_wdata;
        end

        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_last   = i_last_element;
                    n_active = 1'b0;
                    if (!r_match) begin
                        if (r_count < CW'(MAX_LEN)) begin
                            mem_we   = 1'b1;
                            n_k      = r_count[AW-1:0];
                            n_count  = r_count + CW'(1);
                            n_total  = r_total + ssw_pkg::TOTAL_W'(i_element_value);
                            n_active = 1'b1;
                        end else begin
                            n_count = CW'(MAX_LEN + 1);
                        end
                    end
                    n_state = ST_SHRINK;
                end
            end
            ST_SHRINK: begin
                if (pop) begin
                    // drop the oldest element of the window
                    n_total = r_total - ssw_pkg::TOTAL_W'(rd_data);
                    n_head  = r_head + AW'(1);
                end else if (!emit || out_free) begin
                    if (emit) begin
                        n_out_valid = 1'b1;
                        if (hit) begin
                            n_status = ssw_pkg::STATUS_MATCH;
                            n_first  = ssw_pkg::INDEX_W'(r_head);
                            n_wlast  = ssw_pkg::INDEX_W'(r_k);
                        end else begin
                            n_status = (r_count > CW'(MAX_LEN)) ? ssw_pkg::STATUS_OVERFLOW
                                                                : ssw_pkg::STATUS_NO_MATCH;
                            n_first  = '0;
                            n_wlast  = '0;
                        end
                    end
                    if (hit) begin
                        n_match = 1'b1;
                    end
                    // end of array clears the window
                    if (r_last) begin
                        n_total = '0;
                        n_head  = '0;
                        n_count = '0;
                        n_match = 1'b0;
                    end
                    n_active = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_target    <= '0;
            r_total     <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_match     <= 1'b0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_target    <= n_target;
            r_total     <= n_total;
            r_head      <= n_head;
            r_count     <= n_count;
            r_match     <= n_match;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
        r_k      <= n_k;
        r_last   <= n_last;
        r_status <= n_status;
        r_first  <= n_first;
        r_wlast  <= n_wlast;
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_window_first = r_first;
    assign o_window_last  = r_wlast;

    // an accepted item always occupies the block for the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block took a second item straight after the first");

    // window head never passes the newest element while shrinking
    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHRINK && r_active) |-> (r_head <= r_k))
        else $error("window head ran past the newest element");

    // element count saturates one above the limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_LEN + 1))
        else $error("element count beyond saturation");

    // a waiting result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_window_first)
             && $stable(o_window_last)))
        else $error("waiting result was overwritten");

    // a dropped element leaves the running sum non-negative
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_total >= ssw_pkg::TOTAL_W'(rd_data)))
        else $error("window sum would underflow on drop");

endmodule

// File: hdl/ssw_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// standalone, no package dependencies

module ssw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: tb/ssw_tb_pkg.sv
`timescale 1ns / 1ps
// window-sum tracker for the sliding-window subarray sum testbench
// predicts the report of each array and checks the block's reports; depends on ssw_pkg

package ssw_tb_pkg;

    // one report of the block, field for field
    typedef struct packed {
        logic [ssw_pkg::STATUS_W-1:0] status;
        logic [ssw_pkg::INDEX_W-1:0]  run_first;
        logic [ssw_pkg::INDEX_W-1:0]  run_last;
    } t_window_report;

    class sum_window_tracker;

        logic [ssw_pkg::TARGET_W-1:0] target;
        logic [ssw_pkg::ELEM_W-1:0]   elem_mem [ssw_pkg::MAX_LEN_DEF];
        logic [ssw_pkg::TOTAL_W-1:0]  run_total;
        int unsigned                  head;
        int unsigned                  count;
        bit                           matched;
        t_window_report               due_reports [$];
        int                           errors;
        int                           n_match;
        int                           n_no_match;
        int                           n_overflow;

        function new();
            target     = '0;
            errors     = 0;
            n_match    = 0;
            n_no_match = 0;
            n_overflow = 0;
            clear_array();
        endfunction

        function void clear_array();
            run_total = '0;
            head      = 0;
            count     = 0;
            matched   = 1'b0;
        endfunction

        function void set_target(logic [ssw_pkg::TARGET_W-1:0] value);
            target = value;
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        // advance the window by one accepted item and queue the report it causes
        function void note_element(logic [ssw_pkg::ELEM_W-1:0] value, bit is_last);
            t_window_report rep;
            int unsigned    k;
            if (!matched) begin
                if (count < ssw_pkg::MAX_LEN_DEF) begin
                    k = count;
                    elem_mem[k] = value;
                    count = k + 1;
                    run_total = run_total + ssw_pkg::TOTAL_W'(value);
                    // shrink from the oldest end while the sum is too big
                    while (run_total > ssw_pkg::TOTAL_W'(target) && head < k) begin
                        run_total = run_total - ssw_pkg::TOTAL_W'(elem_mem[head]);
                        head++;
                    end
                    if (run_total == ssw_pkg::TOTAL_W'(target)) begin
                        matched = 1'b1;
                        rep.status    = ssw_pkg::STATUS_MATCH;
                        rep.run_first = ssw_pkg::INDEX_W'(head);
                        rep.run_last  = ssw_pkg::INDEX_W'(k);
                        due_reports.push_back(rep);
                    end
                end else begin
                    // past the length limit: remember the overflow, drop the item
                    count = ssw_pkg::MAX_LEN_DEF + 1;
                end
            end
            if (is_last) begin
                if (!matched) begin
                    rep.status    = (count > ssw_pkg::MAX_LEN_DEF) ? ssw_pkg::STATUS_OVERFLOW
                                                                   : ssw_pkg::STATUS_NO_MATCH;
                    rep.run_first = '0;
                    rep.run_last  = '0;
                    due_reports.push_back(rep);
                end
                clear_array();
            end
        endfunction

        // compare one accepted report with the oldest one due
        function void check_report(logic [ssw_pkg::STATUS_W-1:0] status,
                                   logic [ssw_pkg::INDEX_W-1:0]  run_first,
                                   logic [ssw_pkg::INDEX_W-1:0]  run_last);
            t_window_report exp_rep;
            if (due_reports.size() == 0) begin
                errors++;
                $display("%0t: report with none due: status %0d first %0d last %0d",
                         $time, status, run_first, run_last);
                return;
            end
            exp_rep = due_reports.pop_front();
            if (exp_rep.status == ssw_pkg::STATUS_MATCH)
                n_match++;
            else if (exp_rep.status == ssw_pkg::STATUS_NO_MATCH)
                n_no_match++;
            else
                n_overflow++;
            if (status !== exp_rep.status) begin
                errors++;
                $display("%0t: status expected %0d, actual %0d",
                         $time, exp_rep.status, status);
            end
            if (run_first !== exp_rep.run_first) begin
                errors++;
                $display("%0t: window_first expected %0d, actual %0d",
                         $time, exp_rep.run_first, run_first);
            end
            if (run_last !== exp_rep.run_last) begin
                errors++;
                $display("%0t: window_last expected %0d, actual %0d",
                         $time, exp_rep.run_last, run_last);
            end
        endfunction

    endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// testbench top for subarray_sum_sliding_window_top
// drives arrays and target settings, checks reports through ssw_tb_pkg; needs ssw_pkg

module tb_top;

    localparam int RANDOM_ITEMS  = 360;
    localparam int SETTLE_CYCLES = ssw_pkg::MAX_LEN_DEF + 16;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [ssw_pkg::TARGET_W-1:0] cfg_wdata = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [ssw_pkg::ELEM_W-1:0]   element_value = '0;
    logic                         last_element = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [ssw_pkg::STATUS_W-1:0] status;
    logic [ssw_pkg::INDEX_W-1:0]  window_first;
    logic [ssw_pkg::INDEX_W-1:0]  window_last;

    ssw_tb_pkg::sum_window_tracker tracker;
    logic [ssw_pkg::ELEM_W-1:0]    elems [$];
    logic [ssw_pkg::TARGET_W-1:0]  cur_target = '0;
    bit                            no_idle = 1'b0;
    int                            stall_left = 0;
    int                            cycle_count = 0;
    int                            n_elems = 0;
    int                            n_arrays = 0;
    int                            n_settings = 0;

    subarray_sum_sliding_window_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_element_value (element_value),
        .i_last_element  (last_element),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_status        (status),
        .o_window_first  (window_first),
        .o_window_last   (window_last)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** subarray_sum_sliding_window_top: FAILED **");
            $finish;
        end
    end

    // report side: check each accepted report, then stall for a drawn number of cycles
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                tracker.check_report(status, window_first, window_last);
                stall_left = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // offer one item after a drawn gap and wait until it is taken
    task automatic send_element(input logic [ssw_pkg::ELEM_W-1:0] value, input bit is_last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        element_value <= value;
        last_element  <= is_last;
        do @(posedge clk); while (in_stall);
        tracker.note_element(value, is_last);
        n_elems++;
    endtask

    // hold the input until every due report has come
    task automatic drain_reports();
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
    endtask

    // new target only once the block has gone quiet
    task automatic write_target(input logic [ssw_pkg::TARGET_W-1:0] value);
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_target(value);
        cur_target = value;
        n_settings++;
    endtask

    task automatic send_array();
        int i;
        no_idle = ($urandom_range(0, 4) == 0);
        for (i = 0; i < elems.size(); i++) begin
            if ($urandom_range(0, 79) == 0)
                drain_reports();
            send_element(elems[i], i == elems.size() - 1);
        end
        n_arrays++;
    endtask

    function automatic logic [ssw_pkg::ELEM_W-1:0] noise_value(int unsigned top);
        case ($urandom_range(0, 9))
            0:       return ssw_pkg::ELEM_W'($urandom);
            1:       return '0;
            2:       return '1;
            default: return ssw_pkg::ELEM_W'($urandom_range(0, top));
        endcase
    endfunction

    function automatic logic [ssw_pkg::TARGET_W-1:0] pick_target();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 20);
            1:       return $urandom_range(21, 1000);
            2:       return $urandom_range(1001, 65535);
            3:       return $urandom_range(65536, 400000);
            4:       return $urandom;
            default: return $urandom_range(0, 200);
        endcase
    endfunction

    // mostly arrays with a run planted to hit the target, some near misses and pure noise
    task automatic build_array(input logic [ssw_pkg::TARGET_W-1:0] t);
        int          kind;
        int          pre;
        int          run;
        int          post;
        int          i;
        int          min_run;
        int unsigned top;
        longint      goal;
        longint      remaining;
        longint      lo;
        longint      hi;
        longint      part;
        elems.delete();
        kind = $urandom_range(0, 99);
        goal = longint'(t);
        if (kind >= 85) begin
            if ($urandom_range(0, 1) == 0 || goal == 0)
                goal = goal + 1;
            else
                goal = goal - 1;
        end
        min_run = int'((goal + 65534) / 65535);
        if (min_run == 0)
            min_run = 1;
        if (min_run > 24 && kind < 85)
            kind = 70;
        top = (t > 65535) ? 65535 : t / 2 + 1;
        if ((kind < 60 || kind >= 85) && min_run <= 24) begin
            pre  = $urandom_range(0, 12);
            run  = min_run + $urandom_range(0, 4);
            post = $urandom_range(0, 6);
            for (i = 0; i < pre; i++)
                elems.push_back(noise_value(top));
            // split the goal over the run, every part within 16 bits
            remaining = goal;
            for (i = 0; i < run; i++) begin
                if (i == run - 1) begin
                    part = remaining;
                end else begin
                    lo = remaining - 64'd65535 * (run - 1 - i);
                    if (lo < 0)
                        lo = 0;
                    hi = (remaining < 65535) ? remaining : 65535;
                    part = lo + $urandom_range(0, int'(hi - lo));
                end
                remaining = remaining - part;
                elems.push_back(ssw_pkg::ELEM_W'(part));
            end
            for (i = 0; i < post; i++)
                elems.push_back(noise_value(top));
        end else begin
            run = $urandom_range(1, 30);
            for (i = 0; i < run; i++)
                elems.push_back(noise_value(top));
        end
    endtask

    task automatic send_list(input logic [ssw_pkg::ELEM_W-1:0] vals [$]);
        elems = vals;
        send_array();
    endtask

    initial begin
        int start_elems;
        int phase_end;
        tracker = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: single-element match, drop of a huge head, items after a match
        write_target(32'd100);
        send_list('{16'd100});
        send_list('{16'hFFFF, 16'd40, 16'd60, 16'd5});
        send_list('{16'd1, 16'd2, 16'd97});
        send_list('{16'd1, 16'd2, 16'd3});

        // zero target, then the largest target
        write_target(32'd0);
        send_list('{16'd0});
        send_list('{16'd5, 16'd0, 16'd7});
        send_list('{16'hFFFF});
        write_target(32'hFFFF_FFFF);
        send_list('{16'hFFFF, 16'hFFFF, 16'hFFFF});

        // random phases, each under its own target
        start_elems = n_elems;
        while (n_elems - start_elems < RANDOM_ITEMS) begin
            write_target(pick_target());
            phase_end = n_elems + $urandom_range(120, 260);
            while (n_elems < phase_end && n_elems - start_elems < RANDOM_ITEMS) begin
                build_array(cur_target);
                send_array();
            end
        end

        // length limit: one item over, so the over-length report is due
        write_target(32'hFFFF_FFFF);
        elems.delete();
        repeat (ssw_pkg::MAX_LEN_DEF + 1) elems.push_back(ssw_pkg::ELEM_W'($urandom));
        send_array();

        // short arrays again after the long one
        write_target($urandom_range(0, 5000));
        repeat (20) begin
            build_array(cur_target);
            send_array();
        end

        // wind down and let any late report show up
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d elements in %0d arrays under %0d target settings",
                 n_elems, n_arrays, n_settings);
        $display("reports checked: %0d match, %0d no match, %0d over length",
                 tracker.n_match, tracker.n_no_match, tracker.n_overflow);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("** subarray_sum_sliding_window_top: PASSED **");
        end else begin
            $display("** subarray_sum_sliding_window_top: FAILED **");
        end
        $finish;
    end

endmodule
